FILE: rtl/core/sfc_pkg.sv
package sfc_pkg;

   // frame buffer geometry
   localparam int BUF_DEPTH = 64;
   localparam int IDX_W     = $clog2(BUF_DEPTH);
   localparam int POS_W     = $clog2(BUF_DEPTH + 1);
   localparam int CHAR_W    = 7;

   // delimiters after parity strip
   localparam logic [CHAR_W-1:0] CHAR_STX = 7'h02;
   localparam logic [CHAR_W-1:0] CHAR_ETX = 7'h03;

   // command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic {
      OP_DATA  = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [CHAR_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] last_idx;
   } frame_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_SEND
   } back_state_type;

endpackage

FILE: rtl/core/stx_etx_frame_collector.sv
// the first byte of a frame is offered after the frame is queued and the back steps from idle through fetch
// throughput: one received word per cycle while no frame is pending
// a completed frame goes out byte by byte, each through a fetch state (registered buffer read) and then
// a send state (output), and the input stalls until its last byte is taken
// reset (synchronous, active high) clears position, delimiter flags, queue and output state;
// buffer contents are not cleared
module stx_etx_frame_collector
   import sfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // received words
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // rx_byte [7:0]
   input  logic       req_tuser,   // opcode [0]: 0 data byte, 1 fifo overflow flush
   // frame bytes out
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // frame_byte [6:0], zero [7]
   output logic       rsp_tlast    // frame_last
);

   logic              accept;
   mem_wr_type        mem_wr;
   frame_cmd_type     cmd_push;
   q_stat_type        q_stat;
   logic [IDX_W-1:0]  head_idx;
   logic              cmd_pop;
   logic [CHAR_W-1:0] out_byte;

   // the buffer is shared: no new word while a frame is waiting or being read out
   assign req_tready = q_stat.empty;
   assign accept     = req_tvalid && req_tready;

   // front: parity strip, delimiter tracking, buffer write
   sfc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .opcode   (req_tuser),
      .rx_byte  (req_tdata),
      .mem_wr   (mem_wr),
      .cmd_push (cmd_push)
   );

   // completed frames waiting for read out
   sfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .pop      (cmd_pop),
      .head_idx (head_idx),
      .stat     (q_stat)
   );

   // back: buffer read out, one byte per output word
   sfc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .mem_wr       (mem_wr),
      .cmd_empty    (q_stat.empty),
      .cmd_last_idx (head_idx),
      .cmd_pop      (cmd_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (out_byte),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_byte};

endmodule

FILE: rtl/core/sfc_front.sv
module sfc_front
   import sfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic          opcode,
   input  logic [7:0]    rx_byte,
   output mem_wr_type    mem_wr,
   output frame_cmd_type cmd_push
);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              start_ff, start_in;
   logic              end_ff, end_in;
   logic [POS_W-1:0]  base_pos;
   logic              base_start;
   logic              base_end;
   logic [CHAR_W-1:0] chr;
   logic              s_now;
   logic              e_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= 1'b0;
         end_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   always_comb begin
      // buffer full: start over before storing
      if (pos_ff >= POS_W'(BUF_DEPTH)) begin
         base_pos   = '0;
         base_start = 1'b0;
         base_end   = 1'b0;
      end else begin
         base_pos   = pos_ff;
         base_start = start_ff;
         base_end   = end_ff;
      end
      chr   = rx_byte[CHAR_W-1:0];
      s_now = base_start | (chr == CHAR_STX);
      e_now = base_end | (chr == CHAR_ETX);

      pos_in   = pos_ff;
      start_in = start_ff;
      end_in   = end_ff;

      mem_wr.en          = 1'b0;
      mem_wr.addr        = base_pos[IDX_W-1:0];
      mem_wr.data        = chr;
      cmd_push.valid     = 1'b0;
      cmd_push.last_idx  = base_pos[IDX_W-1:0];

      if (accept) begin
         if (opcode == OP_FLUSH) begin
            pos_in   = '0;
            start_in = 1'b0;
            end_in   = 1'b0;
         end else begin
            mem_wr.en = 1'b1;
            if (s_now && e_now) begin
               cmd_push.valid = 1'b1;
               pos_in         = '0;
               start_in       = 1'b0;
               end_in         = 1'b0;
            end else begin
               pos_in   = s_now ? base_pos + POS_W'(1) : base_pos;
               start_in = s_now;
               end_in   = e_now;
            end
         end
      end
   end

endmodule

FILE: rtl/core/sfc_queue.sv
module sfc_queue
   import sfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  frame_cmd_type    push,
   input  logic             pop,
   output logic [IDX_W-1:0] head_idx,
   output q_stat_type       stat
);

   logic [IDX_W-1:0]   entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.last_idx;
      end
   end

   always_comb begin
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
      do_push    = push.valid && !stat.full;
      do_pop     = pop && !stat.empty;
      wr_ptr_in  = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
      head_idx   = entry_ff[rd_ptr_ff];
   end

endmodule

FILE: rtl/core/sfc_back.sv
module sfc_back
   import sfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mem_wr_type        mem_wr,
   input  logic              cmd_empty,
   input  logic [IDX_W-1:0]  cmd_last_idx,
   output logic              cmd_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CHAR_W-1:0] out_byte,
   output logic              out_last
);

   logic [CHAR_W-1:0] frame_mem [BUF_DEPTH];
   logic [CHAR_W-1:0] rdata_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   back_state_type    state_ff, state_in;

   // one write port from the front, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         frame_mem[mem_wr.addr] <= mem_wr.data;
      end
      rdata_ff <= frame_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd_pop   = 1'b0;
      out_valid = 1'b0;
      out_byte  = rdata_ff;
      out_last  = (idx_ff == cmd_last_idx);
      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               idx_in   = '0;
               state_in = BK_FETCH;
            end
         end
         BK_FETCH: begin
            state_in = BK_SEND;
         end
         BK_SEND: begin
            out_valid = 1'b1;
            if (out_ready) begin
               if (out_last) begin
                  cmd_pop  = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = BK_FETCH;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/sfc_checker.sv
module sfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // stalled input word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("input word changed while stalled");

   // stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("output word changed while stalled");

   // parity bit never reaches the output
   a_no_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7] == 1'b0)
      else $error("bit 7 set on output word");

   // input is held off while a frame is read out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during frame read out");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind stx_etx_frame_collector sfc_checker u_sfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
